>>> src/grid_table_interpolator_macros.svh
// ----------------------------------------------------------------------------
// grid_table_interpolator_macros.svh
// Assertion macros used by the grid_table_interpolator module.
// ----------------------------------------------------------------------------
`ifndef GRID_TABLE_INTERPOLATOR_MACROS_SVH
`define GRID_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define GTI_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid table interpolator check failed");

// next-cycle implication, checked outside reset
`define GTI_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid table interpolator check failed");

`endif

>>> src/gti_pkg.sv
// ----------------------------------------------------------------------------
// gti_pkg
// Codes and state types shared by the grid table interpolator modules.
// ----------------------------------------------------------------------------
package gti_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // main sequencer
  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CHK,
    S_NEWROW,
    S_RSH_RD,
    S_RSH_WR,
    S_RNEW,
    S_PS_START,
    S_PS_RD,
    S_PS_CHK,
    S_PSH_RD,
    S_PSH_WR,
    S_PWR,
    S_Q_RD,
    S_Q_CHK,
    S_EV_INIT,
    S_EV_RD,
    S_EV_CHK,
    S_LGO,
    S_LWAIT,
    S_DONE
  } gti_state_t;

  // interpolation unit
  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN,
    L_DONE
  } lerp_state_t;

endpackage

>>> src/grid_table_interpolator.sv
// ----------------------------------------------------------------------------
// grid_table_interpolator
// Irregular two-level table (rows keyed by r, points (u, x) per row) with
// load, clear and bilinear query, signed fixed point.
// ----------------------------------------------------------------------------
// One request at a time. A load searches the row directory for its row,
// opens a new row in key order if none has its key by shifting later
// directory entries up, then searches the row's points for its place and
// shifts the row's later points; every step is a registered read of the row
// or point memory followed by a compare or write. A query searches the rows,
// then the points of each bracketing row, and runs up to three
// interpolations in the shared multiply/divide unit. Clear and unused codes
// go straight to the result hand-off.
// Rows are never moved in the point memory: each row keeps the slot it was
// opened in and only the row directory is kept sorted.
`include "grid_table_interpolator_macros.svh"

module grid_table_interpolator #(
  parameter int MAX_ROWS           = 64,
  parameter int MAX_POINTS_PER_ROW = 64,
  parameter int VALUE_WIDTH        = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gti_pkg::FUNC_W-1:0]      in_func,
  input  logic signed [VALUE_WIDTH-1:0]   in_key_r,
  input  logic signed [VALUE_WIDTH-1:0]   in_key_u,
  input  logic signed [VALUE_WIDTH-1:0]   in_table_x,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [VALUE_WIDTH-1:0]   out_value,
  output logic [gti_pkg::STATUS_W-1:0]    out_status
);
  import gti_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int RIW  = $clog2(MAX_ROWS + 1);
  localparam int PAW  = $clog2(MAX_POINTS_PER_ROW);
  localparam int PIW  = $clog2(MAX_POINTS_PER_ROW + 1);
  localparam int PTAW = RAW + PAW;

  typedef struct packed {
    logic signed [VW-1:0] key;
    logic [PIW-1:0]       len;
    logic [RAW-1:0]       slot;
  } row_ent_t;

  typedef struct packed {
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] x;
  } pt_ent_t;

  // row directory, sorted by key; points stored per slot
  row_ent_t row_mem [2**RAW];
  pt_ent_t  pt_mem  [2**PTAW];

  row_ent_t            row_rd_r;
  pt_ent_t             pt_rd_r;
  logic                row_we;
  logic [RAW-1:0]      row_waddr;
  logic [RAW-1:0]      row_raddr;
  row_ent_t            row_wdata;
  logic                pt_we;
  logic [PTAW-1:0]     pt_waddr;
  logic [PTAW-1:0]     pt_raddr;
  pt_ent_t             pt_wdata;

  gti_state_t           state_r, state_nxt;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic signed [VW-1:0] r_r, r_nxt;
  logic signed [VW-1:0] u_r, u_nxt;
  logic signed [VW-1:0] x_r, x_nxt;
  logic [RIW-1:0]       row_count_r, row_count_nxt;
  logic [RIW-1:0]       ridx_r, ridx_nxt;
  logic [RIW-1:0]       j_r, j_nxt;
  logic [PIW-1:0]       n_r, n_nxt;
  logic [PIW-1:0]       k_r, k_nxt;
  logic [PIW-1:0]       pidx_r, pidx_nxt;
  logic [RAW-1:0]       slot_r, slot_nxt;
  row_ent_t             lo_r, lo_nxt;
  row_ent_t             hi_r, hi_nxt;
  logic                 single_r, single_nxt;
  logic                 ev_hi_r, ev_hi_nxt;
  logic signed [VW-1:0] prev_u_r, prev_u_nxt;
  logic signed [VW-1:0] prev_x_r, prev_x_nxt;
  logic signed [VW-1:0] y0_r, y0_nxt;
  logic signed [VW-1:0] lp_p_r, lp_p_nxt;
  logic signed [VW-1:0] lp_a0_r, lp_a0_nxt;
  logic signed [VW-1:0] lp_x0_r, lp_x0_nxt;
  logic signed [VW-1:0] lp_a1_r, lp_a1_nxt;
  logic signed [VW-1:0] lp_x1_r, lp_x1_nxt;
  logic                 lp_isr_r, lp_isr_nxt;
  logic signed [VW-1:0] res_val_r, res_val_nxt;
  logic [STATUS_W-1:0]  res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic [RIW-1:0]       ridx_inc;
  logic [PIW-1:0]       pidx_inc;
  logic [PIW-1:0]       n_inc;
  logic                 fin;
  logic signed [VW-1:0] fin_val;
  row_ent_t             ev_ent;
  logic                 lerp_start;
  logic                 lerp_done;
  logic signed [VW-1:0] lerp_y;

  assign ridx_inc = ridx_r + RIW'(1);
  assign pidx_inc = pidx_r + PIW'(1);
  assign n_inc    = n_r + PIW'(1);
  assign ev_ent   = ev_hi_r ? hi_r : lo_r;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd_r <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd_r <= pt_mem[pt_raddr];
  end

  // shared interpolation unit
  gti_lerp #(
    .VALUE_WIDTH(VW)
  ) u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .p     (lp_p_r),
    .a0    (lp_a0_r),
    .x0    (lp_x0_r),
    .a1    (lp_a1_r),
    .x1    (lp_x1_r),
    .done  (lerp_done),
    .y     (lerp_y)
  );

  // next state and register updates
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    r_nxt          = r_r;
    u_nxt          = u_r;
    x_nxt          = x_r;
    row_count_nxt  = row_count_r;
    ridx_nxt       = ridx_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    pidx_nxt       = pidx_r;
    slot_nxt       = slot_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    single_nxt     = single_r;
    ev_hi_nxt      = ev_hi_r;
    prev_u_nxt     = prev_u_r;
    prev_x_nxt     = prev_x_r;
    y0_nxt         = y0_r;
    lp_p_nxt       = lp_p_r;
    lp_a0_nxt      = lp_a0_r;
    lp_x0_nxt      = lp_x0_r;
    lp_a1_nxt      = lp_a1_r;
    lp_x1_nxt      = lp_x1_r;
    lp_isr_nxt     = lp_isr_r;
    res_val_nxt    = res_val_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    fin            = 1'b0;
    fin_val        = '0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          r_nxt       = in_key_r;
          u_nxt       = in_key_u;
          x_nxt       = in_table_x;
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          ridx_nxt    = '0;
          case (in_func)
            FUNC_LOAD: begin
              if (row_count_r == '0) begin
                j_nxt     = '0;
                state_nxt = S_NEWROW;
              end else begin
                state_nxt = S_LD_RD;
              end
            end
            FUNC_QUERY: begin
              if (row_count_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_Q_RD;
              end
            end
            FUNC_CLEAR: begin
              row_count_nxt = '0;
              state_nxt     = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // load: find the first row with key >= r
      S_LD_RD: begin
        state_nxt = S_LD_CHK;
      end
      S_LD_CHK: begin
        if (row_rd_r.key < r_r) begin
          if (ridx_inc == row_count_r) begin
            j_nxt     = row_count_r;
            state_nxt = S_NEWROW;
          end else begin
            ridx_nxt  = ridx_inc;
            state_nxt = S_LD_RD;
          end
        end else begin
          j_nxt = ridx_r;
          if (row_rd_r.key == r_r) begin
            if (row_rd_r.len >= PIW'(MAX_POINTS_PER_ROW)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              slot_nxt  = row_rd_r.slot;
              n_nxt     = row_rd_r.len;
              state_nxt = S_PS_START;
            end
          end else begin
            state_nxt = S_NEWROW;
          end
        end
      end

      // open a row at position j, shifting later entries up
      S_NEWROW: begin
        if (row_count_r >= RIW'(MAX_ROWS)) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else if (j_r < row_count_r) begin
          ridx_nxt  = row_count_r - RIW'(1);
          state_nxt = S_RSH_RD;
        end else begin
          state_nxt = S_RNEW;
        end
      end
      S_RSH_RD: begin
        state_nxt = S_RSH_WR;
      end
      S_RSH_WR: begin
        if (ridx_r == j_r) begin
          state_nxt = S_RNEW;
        end else begin
          ridx_nxt  = ridx_r - RIW'(1);
          state_nxt = S_RSH_RD;
        end
      end
      S_RNEW: begin
        slot_nxt      = row_count_r[RAW-1:0];
        row_count_nxt = ridx_inc - ridx_r + row_count_r;
        n_nxt         = '0;
        state_nxt     = S_PS_START;
      end

      // find insert position: after points with u_k <= u
      S_PS_START: begin
        pidx_nxt = '0;
        if (n_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_PWR;
        end else begin
          state_nxt = S_PS_RD;
        end
      end
      S_PS_RD: begin
        state_nxt = S_PS_CHK;
      end
      S_PS_CHK: begin
        if (pt_rd_r.u <= u_r) begin
          if (pidx_inc == n_r) begin
            k_nxt     = n_r;
            state_nxt = S_PWR;
          end else begin
            pidx_nxt  = pidx_inc;
            state_nxt = S_PS_RD;
          end
        end else begin
          k_nxt     = pidx_r;
          pidx_nxt  = n_r - PIW'(1);
          state_nxt = S_PSH_RD;
        end
      end
      S_PSH_RD: begin
        state_nxt = S_PSH_WR;
      end
      S_PSH_WR: begin
        if (pidx_r == k_r) begin
          state_nxt = S_PWR;
        end else begin
          pidx_nxt  = pidx_r - PIW'(1);
          state_nxt = S_PSH_RD;
        end
      end
      S_PWR: begin
        state_nxt = S_DONE;
      end

      // query: bracket r among the row keys
      S_Q_RD: begin
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (!(row_rd_r.key < r_r) || (ridx_inc == row_count_r)) begin
          hi_nxt     = row_rd_r;
          single_nxt = (ridx_r == '0) || (row_rd_r.key < r_r);
          ev_hi_nxt  = (ridx_r == '0) || (row_rd_r.key < r_r);
          state_nxt  = S_EV_INIT;
        end else begin
          lo_nxt    = row_rd_r;
          ridx_nxt  = ridx_inc;
          state_nxt = S_Q_RD;
        end
      end

      // evaluate one row at u
      S_EV_INIT: begin
        slot_nxt = ev_ent.slot;
        n_nxt    = ev_ent.len;
        pidx_nxt = '0;
        if (ev_ent.len == '0) begin
          fin     = 1'b1;
          fin_val = '0;
        end else begin
          state_nxt = S_EV_RD;
        end
      end
      S_EV_RD: begin
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (!(pt_rd_r.u < u_r) || (pidx_inc == n_r)) begin
          if ((pidx_r == '0) || (pt_rd_r.u < u_r)) begin
            fin     = 1'b1;
            fin_val = pt_rd_r.x;
          end else begin
            lp_p_nxt   = u_r;
            lp_a0_nxt  = prev_u_r;
            lp_x0_nxt  = prev_x_r;
            lp_a1_nxt  = pt_rd_r.u;
            lp_x1_nxt  = pt_rd_r.x;
            lp_isr_nxt = 1'b0;
            state_nxt  = S_LGO;
          end
        end else begin
          prev_u_nxt = pt_rd_r.u;
          prev_x_nxt = pt_rd_r.x;
          pidx_nxt   = pidx_inc;
          state_nxt  = S_EV_RD;
        end
      end

      // interpolation unit
      S_LGO: begin
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (lerp_done) begin
          if (lp_isr_r) begin
            res_val_nxt = lerp_y;
            state_nxt   = S_DONE;
          end else begin
            fin     = 1'b1;
            fin_val = lerp_y;
          end
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_val_r;
          out_status_nxt = res_st_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a row value is ready: next row, final result or the r step
    if (fin) begin
      if (!ev_hi_r) begin
        y0_nxt    = fin_val;
        ev_hi_nxt = 1'b1;
        state_nxt = S_EV_INIT;
      end else if (single_r) begin
        res_val_nxt = fin_val;
        state_nxt   = S_DONE;
      end else begin
        lp_p_nxt   = r_r;
        lp_a0_nxt  = lo_r.key;
        lp_x0_nxt  = y0_r;
        lp_a1_nxt  = hi_r.key;
        lp_x1_nxt  = fin_val;
        lp_isr_nxt = 1'b1;
        state_nxt  = S_LGO;
      end
    end
  end

  // memory and unit controls, handshake outputs
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    out_valid  = out_valid_r;
    out_value  = out_value_r;
    out_status = out_status_r;
    lerp_start = (state_r == S_LGO);

    row_raddr = ridx_r[RAW-1:0];
    row_we    = (state_r == S_RSH_WR) || (state_r == S_PWR);
    if (state_r == S_RSH_WR) begin
      row_waddr = ridx_inc[RAW-1:0];
      row_wdata = row_rd_r;
    end else begin
      row_waddr      = j_r[RAW-1:0];
      row_wdata.key  = r_r;
      row_wdata.len  = n_inc;
      row_wdata.slot = slot_r;
    end

    pt_raddr = {slot_r, pidx_r[PAW-1:0]};
    pt_we    = (state_r == S_PSH_WR) || (state_r == S_PWR);
    if (state_r == S_PSH_WR) begin
      pt_waddr = {slot_r, pidx_inc[PAW-1:0]};
      pt_wdata = pt_rd_r;
    end else begin
      pt_waddr   = {slot_r, k_r[PAW-1:0]};
      pt_wdata.u = u_r;
      pt_wdata.x = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    r_r          <= r_nxt;
    u_r          <= u_nxt;
    x_r          <= x_nxt;
    ridx_r       <= ridx_nxt;
    j_r          <= j_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    pidx_r       <= pidx_nxt;
    slot_r       <= slot_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    single_r     <= single_nxt;
    ev_hi_r      <= ev_hi_nxt;
    prev_u_r     <= prev_u_nxt;
    prev_x_r     <= prev_x_nxt;
    y0_r         <= y0_nxt;
    lp_p_r       <= lp_p_nxt;
    lp_a0_r      <= lp_a0_nxt;
    lp_x0_r      <= lp_x0_nxt;
    lp_a1_r      <= lp_a1_nxt;
    lp_x1_r      <= lp_x1_nxt;
    lp_isr_r     <= lp_isr_nxt;
    res_val_r    <= res_val_nxt;
    res_st_r     <= res_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // checks
  `GTI_CHK_IMP(a_count_bound, 1'b1, row_count_r <= RIW'(MAX_ROWS))
  `GTI_CHK_IMP(a_shift_room, state_r == S_RSH_WR, row_count_r < RIW'(MAX_ROWS))
  `GTI_CHK_NXT(a_done_hands_off, (state_r == S_DONE) && (!out_valid_r || out_ready), out_valid_r && (state_r == S_IDLE))
  `GTI_CHK_IMP(a_point_room, state_r == S_PWR, n_r < PIW'(MAX_POINTS_PER_ROW))

endmodule

>>> src/gti_lerp.sv
// ----------------------------------------------------------------------------
// gti_lerp
// Multicycle linear interpolation: x0 + sign(x1-x0)*floor(|x1-x0|*(p-a0)/(a1-a0)),
// with a shift-add multiply followed by a restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module gti_lerp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] p,
  input  logic signed [VALUE_WIDTH-1:0] a0,
  input  logic signed [VALUE_WIDTH-1:0] x0,
  input  logic signed [VALUE_WIDTH-1:0] a1,
  input  logic signed [VALUE_WIDTH-1:0] x1,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] y
);
  import gti_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(VW);

  lerp_state_t             st_r, st_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [VW-1:0]           da_r, da_nxt;
  logic [VW-1:0]           dp_r, dp_nxt;
  logic [VW-1:0]           dx_r, dx_nxt;
  logic signed [VW-1:0]    x0_r, x0_nxt;
  logic                    up_r, up_nxt;
  logic [2*VW-1:0]         prod_r, prod_nxt;
  logic [VW-1:0]           q_r, q_nxt;
  logic signed [VW-1:0]    y_r, y_nxt;

  logic                    bad;
  logic [VW:0]             trial;
  logic [VW:0]             trial_sub;
  logic                    ge;
  logic [VW-1:0]           rem;

  // divide step: partial remainder with next dividend bit
  assign trial     = {prod_r[2*VW-1:VW], prod_r[VW-1]};
  assign trial_sub = trial - {1'b0, da_r};
  assign ge        = (trial >= {1'b0, da_r});
  assign rem       = ge ? trial_sub[VW-1:0] : trial[VW-1:0];

  // point outside the open-closed segment, or empty segment
  assign bad = !(a0 < a1) || !(a0 < p) || !(p <= a1);

  // next state and datapath
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    da_nxt   = da_r;
    dp_nxt   = dp_r;
    dx_nxt   = dx_r;
    x0_nxt   = x0_r;
    up_nxt   = up_r;
    prod_nxt = prod_r;
    q_nxt    = q_r;
    y_nxt    = y_r;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          x0_nxt = x0;
          if (bad) begin
            q_nxt  = '0;
            up_nxt = 1'b1;
            st_nxt = L_FIN;
          end else begin
            da_nxt   = a1 - a0;
            dp_nxt   = p - a0;
            up_nxt   = (x0 <= x1);
            dx_nxt   = (x0 <= x1) ? (x1 - x0) : (x0 - x1);
            prod_nxt = '0;
            cnt_nxt  = CW'(VW - 1);
            st_nxt   = L_MUL;
          end
        end
      end
      L_MUL: begin
        prod_nxt = {prod_r[2*VW-2:0], 1'b0} + (dp_r[cnt_r] ? {{VW{1'b0}}, dx_r} : '0);
        if (cnt_r == '0) begin
          cnt_nxt = CW'(VW - 1);
          st_nxt  = L_DIV;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      L_DIV: begin
        prod_nxt = {rem, prod_r[VW-2:0], 1'b0};
        q_nxt    = {q_r[VW-2:0], ge};
        if (cnt_r == '0) begin
          st_nxt = L_FIN;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      L_FIN: begin
        y_nxt  = up_r ? (x0_r + $signed(q_r)) : (x0_r - $signed(q_r));
        st_nxt = L_DONE;
      end
      L_DONE: begin
        st_nxt = L_IDLE;
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    done = (st_r == L_DONE);
    y    = y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    cnt_r  <= cnt_nxt;
    da_r   <= da_nxt;
    dp_r   <= dp_nxt;
    dx_r   <= dx_nxt;
    x0_r   <= x0_nxt;
    up_r   <= up_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
    y_r    <= y_nxt;
  end

endmodule
